FILE: rtl/core/qconv_pkg.sv
// ============================================================================
// qconv_pkg: shared constants and types of the 5x5 quantized convolution
// Sizes, fixed-point formats, register indexes and the stage word types.
// ============================================================================
package qconv_pkg;

   localparam int LINE_WIDTH  = 32;
   localparam int KERNEL_SIZE = 5;
   localparam int SCALE_SHIFT = 7;

   localparam int TAPS        = KERNEL_SIZE * KERNEL_SIZE;
   localparam int STORED_ROWS = KERNEL_SIZE - 1;
   localparam int COL_W       = $clog2(LINE_WIDTH);
   localparam int ROWS_W      = $clog2(STORED_ROWS + 1);

   localparam int PIX_W       = 16;
   localparam int PIX_FRAC    = 12;
   localparam int WT_W        = 8;
   localparam int PROD_W      = PIX_W + WT_W;
   localparam int ROWSUM_W    = PROD_W + $clog2(KERNEL_SIZE);
   localparam int ACC_W       = 32;
   localparam int TOTAL_W     = ACC_W + 2;
   localparam int ACT_W       = 15;
   localparam int RW_W        = 11;

   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHTS_A   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHTS_B   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHTS_C   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_LAST = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS_CODE   = 3'd5;

   localparam logic [RW_W-1:0] ROW_WIDTH_RESET = 11'd32;
   localparam logic [RW_W-1:0] ROW_WIDTH_MIN   = RW_W'(KERNEL_SIZE);
   localparam logic [RW_W-1:0] ROW_WIDTH_MAX   = RW_W'(LINE_WIDTH);

   typedef logic [TAPS-1:0][PIX_W-1:0]        taps_type;
   typedef logic [TAPS-1:0][WT_W-1:0]         weights_type;
   typedef logic [STORED_ROWS-1:0][PIX_W-1:0] col_word_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] partial;
      logic                    final_channel;
      logic                    row_end;
   } meta_type;

endpackage

FILE: rtl/core/qconv_window.sv
// ============================================================================
// qconv_window: line store, raster position and 5x5 window
// Reads one stored column per pixel, rotates it and shifts the window.
// ============================================================================
module qconv_window (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [qconv_pkg::RW_W-1:0]         row_width,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic signed [qconv_pkg::PIX_W-1:0] pixel,
   input  logic                               frame_start,
   input  logic signed [qconv_pkg::ACC_W-1:0] partial_in,
   input  logic                               final_channel,
   output logic                               win_valid,
   input  logic                               win_ready,
   output qconv_pkg::taps_type                win_taps,
   output qconv_pkg::meta_type                win_meta
);

   localparam int K = qconv_pkg::KERNEL_SIZE;
   localparam int SR = qconv_pkg::STORED_ROWS;

   logic [qconv_pkg::COL_W-1:0]  column_pos_ff, column_pos_in;
   logic [qconv_pkg::ROWS_W-1:0] rows_seen_ff, rows_seen_in;

   logic                               s1_valid_ff;
   logic signed [qconv_pkg::PIX_W-1:0] s1_pixel_ff;
   logic [qconv_pkg::COL_W-1:0]        s1_col_ff;
   logic                               s1_result_ff;
   qconv_pkg::meta_type                s1_meta_ff;
   logic                               s1_fwd_ff;
   qconv_pkg::col_word_type            fwd_word_ff;
   qconv_pkg::col_word_type            rd_word_ff;

   qconv_pkg::col_word_type line_mem [qconv_pkg::LINE_WIDTH];

   logic                    win_valid_ff;
   qconv_pkg::taps_type     taps_ff;
   qconv_pkg::meta_type     win_meta_ff;

   logic                         accept, commit, hit, has_result, at_end;
   logic [qconv_pkg::RW_W-1:0]   rw_eff, last_col;
   logic [qconv_pkg::COL_W-1:0]  col;
   logic [qconv_pkg::ROWS_W-1:0] rows;
   qconv_pkg::col_word_type      col_word, wr_word;

   assign commit   = s1_valid_ff && (!win_valid_ff || win_ready);
   assign in_ready = !s1_valid_ff || commit;
   assign accept   = in_valid && in_ready;

   always_comb begin
      if (row_width < qconv_pkg::ROW_WIDTH_MIN) begin
         rw_eff = qconv_pkg::ROW_WIDTH_MIN;
      end else if (row_width > qconv_pkg::ROW_WIDTH_MAX) begin
         rw_eff = qconv_pkg::ROW_WIDTH_MAX;
      end else begin
         rw_eff = row_width;
      end
      last_col   = rw_eff - qconv_pkg::RW_W'(1);
      col        = frame_start ? '0 : column_pos_ff;
      rows       = frame_start ? '0 : rows_seen_ff;
      has_result = (rows == qconv_pkg::ROWS_W'(SR)) &&
                   (col >= qconv_pkg::COL_W'(K - 1));
      at_end     = qconv_pkg::RW_W'(col) >= last_col;

      column_pos_in = column_pos_ff;
      rows_seen_in  = rows_seen_ff;
      if (accept) begin
         if (at_end) begin
            column_pos_in = '0;
            rows_seen_in  = (rows < qconv_pkg::ROWS_W'(SR)) ?
                            rows + qconv_pkg::ROWS_W'(1) : rows;
         end else begin
            column_pos_in = col + qconv_pkg::COL_W'(1);
            rows_seen_in  = rows;
         end
      end
   end

   // stale read when the word being written is the one just read
   assign col_word = s1_fwd_ff ? fwd_word_ff : rd_word_ff;
   assign hit      = commit && (s1_col_ff == col);

   always_comb begin
      for (int r = 0; r < SR - 1; r++) begin
         wr_word[r] = col_word[r + 1];
      end
      wr_word[SR-1] = s1_pixel_ff;
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         line_mem[s1_col_ff] <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_word_ff <= line_mem[col];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_pos_ff <= '0;
         rows_seen_ff  <= '0;
         s1_valid_ff   <= 1'b0;
         win_valid_ff  <= 1'b0;
      end else begin
         column_pos_ff <= column_pos_in;
         rows_seen_ff  <= rows_seen_in;
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (commit) begin
            s1_valid_ff <= 1'b0;
         end
         if (commit) begin
            win_valid_ff <= s1_result_ff;
         end else if (win_ready) begin
            win_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff                <= pixel;
         s1_col_ff                  <= col;
         s1_result_ff               <= has_result;
         s1_meta_ff.partial         <= partial_in;
         s1_meta_ff.final_channel   <= final_channel;
         s1_meta_ff.row_end         <= at_end;
         s1_fwd_ff                  <= hit;
         fwd_word_ff                <= wr_word;
      end
      if (commit) begin
         for (int r = 0; r < K; r++) begin
            for (int c = 0; c < K - 1; c++) begin
               taps_ff[K*r + c] <= taps_ff[K*r + c + 1];
            end
         end
         for (int r = 0; r < SR; r++) begin
            taps_ff[K*r + K - 1] <= col_word[r];
         end
         taps_ff[qconv_pkg::TAPS-1] <= s1_pixel_ff;
         win_meta_ff <= s1_meta_ff;
      end
   end

   assign win_valid = win_valid_ff;
   assign win_taps  = taps_ff;
   assign win_meta  = win_meta_ff;

endmodule

FILE: rtl/core/qconv_mac.sv
// ============================================================================
// qconv_mac: 25-tap multiply and registered adder tree
// Products, per-row sums, then total with partial sum and 32-bit saturation.
// ============================================================================
module qconv_mac (
   input  logic                               clock,
   input  logic                               reset,
   input  qconv_pkg::weights_type             weights,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  qconv_pkg::taps_type                taps,
   input  qconv_pkg::meta_type                meta,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic signed [qconv_pkg::ACC_W-1:0] sum_out,
   output qconv_pkg::meta_type                out_meta
);

   localparam int K  = qconv_pkg::KERNEL_SIZE;
   localparam int TW = qconv_pkg::TOTAL_W;
   localparam int AW = qconv_pkg::ACC_W;

   logic                                  p_valid_ff, r_valid_ff, t_valid_ff;
   logic                                  p_adv, r_adv, t_adv;
   logic signed [qconv_pkg::PROD_W-1:0]   prod_ff [qconv_pkg::TAPS];
   qconv_pkg::meta_type                   p_meta_ff, r_meta_ff, t_meta_ff;
   logic signed [qconv_pkg::ROWSUM_W-1:0] rowsum_ff [K];
   logic signed [qconv_pkg::ROWSUM_W-1:0] rowsum_in [K];
   logic signed [TW-1:0]                  total_in;
   logic signed [AW-1:0]                  sat_in, sum_ff;

   assign t_adv    = !t_valid_ff || out_ready;
   assign r_adv    = !r_valid_ff || t_adv;
   assign p_adv    = !p_valid_ff || r_adv;
   assign in_ready = p_adv;

   always_comb begin
      for (int r = 0; r < K; r++) begin
         rowsum_in[r] = '0;
         for (int c = 0; c < K; c++) begin
            rowsum_in[r] = rowsum_in[r] + qconv_pkg::ROWSUM_W'(prod_ff[K*r + c]);
         end
      end
   end

   always_comb begin
      total_in = TW'(r_meta_ff.partial);
      for (int r = 0; r < K; r++) begin
         total_in = total_in + TW'(rowsum_ff[r]);
      end
      // clamp when the upper bits disagree with the 32-bit sign
      if (total_in[TW-1:AW-1] == '0 || total_in[TW-1:AW-1] == '1) begin
         sat_in = total_in[AW-1:0];
      end else if (total_in[TW-1]) begin
         sat_in = {1'b1, {(AW-1){1'b0}}};
      end else begin
         sat_in = {1'b0, {(AW-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
         t_valid_ff <= 1'b0;
      end else begin
         if (p_adv) begin
            p_valid_ff <= in_valid;
         end
         if (r_adv) begin
            r_valid_ff <= p_valid_ff;
         end
         if (t_adv) begin
            t_valid_ff <= r_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (p_adv) begin
         for (int k = 0; k < qconv_pkg::TAPS; k++) begin
            prod_ff[k] <= $signed(taps[k]) * $signed(weights[k]);
         end
         p_meta_ff <= meta;
      end
      if (r_adv) begin
         for (int r = 0; r < K; r++) begin
            rowsum_ff[r] <= rowsum_in[r];
         end
         r_meta_ff <= p_meta_ff;
      end
      if (t_adv) begin
         sum_ff    <= sat_in;
         t_meta_ff <= r_meta_ff;
      end
   end

   assign out_valid = t_valid_ff;
   assign sum_out   = sum_ff;
   assign out_meta  = t_meta_ff;

endmodule

FILE: rtl/core/qconv_act.sv
// ============================================================================
// qconv_act: bias, ReLU, rescale and result register
// Holds the result word until it is taken.
// ============================================================================
module qconv_act (
   input  logic                               clock,
   input  logic                               reset,
   input  logic signed [qconv_pkg::WT_W-1:0]  bias_code,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic signed [qconv_pkg::ACC_W-1:0] sum_in,
   input  qconv_pkg::meta_type                meta,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [qconv_pkg::ACC_W-1:0] rsp_sum_out,
   output logic [qconv_pkg::ACT_W-1:0]        rsp_activation,
   output logic                               rsp_row_end
);

   localparam int T_W = qconv_pkg::ACC_W + 1;

   logic                               rsp_valid_ff;
   logic signed [qconv_pkg::ACC_W-1:0] sum_ff;
   logic [qconv_pkg::ACT_W-1:0]        act_ff, act_in;
   logic                               row_end_ff;
   logic signed [T_W-1:0]              t_val, shifted;

   assign in_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      t_val   = T_W'(sum_in) + (T_W'(bias_code) <<< qconv_pkg::PIX_FRAC);
      shifted = t_val >>> qconv_pkg::SCALE_SHIFT;
      if (!meta.final_channel || t_val[T_W-1] || t_val == '0) begin
         act_in = '0;
      end else if (shifted[T_W-1:qconv_pkg::ACT_W] != '0) begin
         act_in = '1;
      end else begin
         act_in = shifted[qconv_pkg::ACT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (in_ready) begin
         rsp_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         sum_ff     <= sum_in;
         act_ff     <= act_in;
         row_end_ff <= meta.row_end;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sum_out    = sum_ff;
   assign rsp_activation = act_ff;
   assign rsp_row_end    = row_end_ff;

endmodule

FILE: rtl/core/quantized_conv5x5_relu.sv
// ============================================================================
// quantized_conv5x5_relu: streaming 5x5 int8-weight convolution with ReLU
// Path: a result word passes the line store read, window, products, row
//   sums, total and activation registers after its last pixel is accepted.
// Throughput: one pixel per cycle while no stage is blocked; the line store
//   reads and writes one column word per cycle, and each stage takes a word
//   each cycle unless the word it holds cannot move on.
// Reset: clears raster position, row count, stage valids and the registers
//   to their reset values; the line store keeps its contents.
// ============================================================================
module quantized_conv5x5_relu (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [qconv_pkg::PIX_W-1:0]      req_pixel,
   input  logic                                    req_frame_start,
   input  logic signed [qconv_pkg::ACC_W-1:0]      req_partial_in,
   input  logic                                    req_final_channel,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [qconv_pkg::ACC_W-1:0]      rsp_sum_out,
   output logic [qconv_pkg::ACT_W-1:0]             rsp_activation,
   output logic                                    rsp_row_end,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [qconv_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [qconv_pkg::CSR_DATA_W-1:0]        csr_data
);

   // configuration registers
   logic [qconv_pkg::RW_W-1:0]        row_width_ff;
   logic [qconv_pkg::CSR_DATA_W-1:0]  weights_a_ff, weights_b_ff, weights_c_ff;
   logic signed [qconv_pkg::WT_W-1:0] weight_last_ff, bias_code_ff;

   qconv_pkg::weights_type weights;

   // window -> multiply stage
   logic                win_vld, win_rdy;
   qconv_pkg::taps_type win_taps;
   qconv_pkg::meta_type win_meta;

   // adder tree -> activation stage
   logic                               mac_vld, mac_rdy;
   logic signed [qconv_pkg::ACC_W-1:0] mac_sum;
   qconv_pkg::meta_type                mac_meta;

   // the port never stalls a configuration word
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff   <= qconv_pkg::ROW_WIDTH_RESET;
         weights_a_ff   <= '0;
         weights_b_ff   <= '0;
         weights_c_ff   <= '0;
         weight_last_ff <= '0;
         bias_code_ff   <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            qconv_pkg::CSR_ROW_WIDTH: begin
               row_width_ff <= csr_data[qconv_pkg::RW_W-1:0];
            end
            qconv_pkg::CSR_WEIGHTS_A: begin
               weights_a_ff <= csr_data;
            end
            qconv_pkg::CSR_WEIGHTS_B: begin
               weights_b_ff <= csr_data;
            end
            qconv_pkg::CSR_WEIGHTS_C: begin
               weights_c_ff <= csr_data;
            end
            qconv_pkg::CSR_WEIGHT_LAST: begin
               weight_last_ff <= csr_data[qconv_pkg::WT_W-1:0];
            end
            qconv_pkg::CSR_BIAS_CODE: begin
               bias_code_ff <= csr_data[qconv_pkg::WT_W-1:0];
            end
            default: begin
               // drop writes past the register list
            end
         endcase
      end
   end

   // weight k sits in byte k of the packed registers, oldest row first
   assign weights = qconv_pkg::weights_type'({weight_last_ff, weights_c_ff,
                                              weights_b_ff, weights_a_ff});

   // line store, raster position and the 5x5 window
   qconv_window u_window (
      .clock         (clock),
      .reset         (reset),
      .row_width     (row_width_ff),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .pixel         (req_pixel),
      .frame_start   (req_frame_start),
      .partial_in    (req_partial_in),
      .final_channel (req_final_channel),
      .win_valid     (win_vld),
      .win_ready     (win_rdy),
      .win_taps      (win_taps),
      .win_meta      (win_meta)
   );

   // products and saturated channel sum
   qconv_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .weights   (weights),
      .in_valid  (win_vld),
      .in_ready  (win_rdy),
      .taps      (win_taps),
      .meta      (win_meta),
      .out_valid (mac_vld),
      .out_ready (mac_rdy),
      .sum_out   (mac_sum),
      .out_meta  (mac_meta)
   );

   // bias, ReLU, rescale; hold the result word until it is taken
   qconv_act u_act (
      .clock          (clock),
      .reset          (reset),
      .bias_code      (bias_code_ff),
      .in_valid       (mac_vld),
      .in_ready       (mac_rdy),
      .sum_in         (mac_sum),
      .meta           (mac_meta),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sum_out    (rsp_sum_out),
      .rsp_activation (rsp_activation),
      .rsp_row_end    (rsp_row_end)
   );

   // nothing is in flight right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !win_vld)
      else $error("pipeline not empty after reset");

   // input stalls only when the window word cannot move on
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (win_vld && !win_rdy))
      else $error("input stalled without a blocked window word");

   // a blocked window word keeps its tags
   a_window_hold: assert property (@(posedge clock) disable iff (reset)
      win_vld && !win_rdy |=> win_vld && $stable(win_meta))
      else $error("window word changed while blocked");

endmodule

FILE: test/testbench.sv
// ============================================================================
// testbench: self-checking bench for the streaming 5x5 quantized convolution
// Streams pixel frames through the block under random handshake gaps and
// stalls, computes every window sum, activation and row-end flag in a
// bit-accurate software copy of the datapath, and compares each result word
// as it leaves the block.
// ============================================================================
module testbench;
   import qconv_pkg::*;

   localparam int     MAX_REPORTS     = 10;
   localparam int     WATCHDOG_LIMIT  = 4000;
   localparam int     DRAIN_CYCLES    = 16;
   localparam int     RSP_HOLD_CYCLES = 300;
   localparam longint SUM_MAX         = 64'sd2147483647;
   localparam longint SUM_MIN         = -64'sd2147483648;
   localparam int     ACT_MAX         = 32767;
   localparam int     BIAS_SCALE      = 1 << PIX_FRAC;

   // First index past the register map; writes there must be dropped.
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_FIRST = CSR_BIAS_CODE + 1'b1;

   typedef struct {
      logic signed [ACC_W-1:0] sum;
      logic [ACT_W-1:0]        act;
      logic                    row_end;
   } window_result_type;

   // ---------------------------------------------------------------------
   // Clock, reset and block ports
   // ---------------------------------------------------------------------
   logic                     clock             = 1'b0;
   logic                     reset             = 1'b1;
   logic                     req_valid         = 1'b0;
   logic                     req_ready;
   logic signed [PIX_W-1:0]  req_pixel         = '0;
   logic                     req_frame_start   = 1'b0;
   logic signed [ACC_W-1:0]  req_partial_in    = '0;
   logic                     req_final_channel = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready         = 1'b0;
   logic signed [ACC_W-1:0]  rsp_sum_out;
   logic [ACT_W-1:0]         rsp_activation;
   logic                     rsp_row_end;
   logic                     csr_valid         = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index         = '0;
   logic [CSR_DATA_W-1:0]    csr_data          = '0;

   always #5 clock = ~clock;

   quantized_conv5x5_relu u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_pixel         (req_pixel),
      .req_frame_start   (req_frame_start),
      .req_partial_in    (req_partial_in),
      .req_final_channel (req_final_channel),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sum_out       (rsp_sum_out),
      .rsp_activation    (rsp_activation),
      .rsp_row_end       (rsp_row_end),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // ---------------------------------------------------------------------
   // Shadow copy of the block: registers, line store, window, raster state
   // ---------------------------------------------------------------------
   logic [RW_W-1:0]         cfg_row_width   = ROW_WIDTH_RESET;
   logic [CSR_DATA_W-1:0]   cfg_weights_a   = '0;
   logic [CSR_DATA_W-1:0]   cfg_weights_b   = '0;
   logic [CSR_DATA_W-1:0]   cfg_weights_c   = '0;
   logic signed [WT_W-1:0]  cfg_weight_last = '0;
   logic signed [WT_W-1:0]  cfg_bias        = '0;

   logic [PIX_W-1:0]        line_mem [STORED_ROWS][LINE_WIDTH] = '{default: '0};
   logic signed [PIX_W-1:0] win [KERNEL_SIZE][KERNEL_SIZE]      = '{default: '0};
   int unsigned             col_pos     = 0;
   int unsigned             rows_filled = 0;

   // Result words still owed by the block, oldest first.
   window_result_type       window_results[$];

   int fail_count    = 0;
   int pixels_sent   = 0;
   int req_idle_pct  = 0;
   int rsp_idle_pct  = 0;
   int rsp_hold_request = 0;
   int rsp_hold_left    = 0;
   int quiet_cycles     = 0;

   // Row width as the block applies it: clamped to what the line store holds.
   function automatic int active_width();
      if (cfg_row_width < ROW_WIDTH_MIN) return KERNEL_SIZE;
      if (cfg_row_width > ROW_WIDTH_MAX) return LINE_WIDTH;
      return int'(cfg_row_width);
   endfunction

   // Tap k sits at window row k/5, column k%5; row 0 is the oldest line.
   function automatic logic signed [WT_W-1:0] tap_weight(input int k);
      logic [CSR_DATA_W-1:0] bank;
      if (k >= TAPS - 1) return cfg_weight_last;
      bank = (k < 8) ? cfg_weights_a : (k < 16) ? cfg_weights_b : cfg_weights_c;
      return bank[WT_W * (k % 8) +: WT_W];
   endfunction

   // Advance the shadow raster by one pixel word; queue the result word when
   // the pixel completes a full 5x5 window.
   function automatic void convolve_pixel(input logic signed [PIX_W-1:0] pix,
                                          input logic fs,
                                          input logic signed [ACC_W-1:0] partial,
                                          input logic fin);
      int unsigned             w;
      int unsigned             col;
      logic signed [PIX_W-1:0] column [KERNEL_SIZE];
      logic                    win_full;
      logic                    row_done;
      longint                  acc;
      longint                  total;
      longint                  shifted;
      window_result_type       res;

      w = active_width();
      // A frame start clears the raster position before the pixel is used.
      if (fs) begin
         col_pos     = 0;
         rows_filled = 0;
      end
      col = (col_pos >= LINE_WIDTH) ? LINE_WIDTH - 1 : col_pos;

      // Read the column of older lines, shift it up by one line, add the pixel.
      for (int r = 0; r < STORED_ROWS; r++) column[r] = line_mem[r][col];
      column[STORED_ROWS] = pix;
      for (int r = 0; r < STORED_ROWS; r++) line_mem[r][col] = column[r + 1];

      for (int r = 0; r < KERNEL_SIZE; r++) begin
         for (int c = 0; c < KERNEL_SIZE - 1; c++) win[r][c] = win[r][c + 1];
         win[r][KERNEL_SIZE - 1] = column[r];
      end

      // A column at or past the last one ends the row, also after the width
      // shrank in the middle of a row.
      win_full = (rows_filled >= STORED_ROWS) && (col >= KERNEL_SIZE - 1);
      row_done = (col >= w - 1);
      if (row_done) begin
         col_pos = 0;
         if (rows_filled < STORED_ROWS) rows_filled++;
      end else begin
         col_pos = col + 1;
      end

      if (!win_full) return;

      acc = 0;
      for (int r = 0; r < KERNEL_SIZE; r++)
         for (int c = 0; c < KERNEL_SIZE; c++)
            acc += longint'(win[r][c]) * longint'(tap_weight(r * KERNEL_SIZE + c));
      total = acc + longint'(partial);
      if (total > SUM_MAX) total = SUM_MAX;
      if (total < SUM_MIN) total = SUM_MIN;
      res.sum = total[ACC_W-1:0];

      // Bias in accumulator units, ReLU, then down to unsigned Q10.5 with saturation.
      res.act = '0;
      if (fin) begin
         shifted = total + longint'(cfg_bias) * BIAS_SCALE;
         if (shifted > 0) begin
            shifted = shifted >>> SCALE_SHIFT;
            if (shifted > ACT_MAX) shifted = ACT_MAX;
            res.act = shifted[ACT_W-1:0];
         end
      end
      res.row_end = row_done;
      window_results.push_back(res);
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic logic signed [PIX_W-1:0] random_pixel(input bit full_range);
      // Small pixels lie in -512 to 511; full-range pixels use every code.
      if (full_range) return PIX_W'($urandom);
      return PIX_W'($urandom_range(1023, 0) - 512);
   endfunction

   function automatic logic signed [ACC_W-1:0] random_partial();
      case ($urandom_range(9, 0))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return $urandom;
         default: return ACC_W'($urandom_range(134217727, 0)) - 32'sd67108864;
      endcase
   endfunction

   // Offer one pixel word, hold it until accepted, then predict its result.
   task automatic send_pixel(input logic signed [PIX_W-1:0] pix, input logic fs,
                             input logic signed [ACC_W-1:0] partial, input logic fin);
      while ($urandom_range(99, 0) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_pixel         <= pix;
      req_frame_start   <= fs;
      req_partial_in    <= partial;
      req_final_channel <= fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      convolve_pixel(pix, fs, partial, fin);
      pixels_sent++;
   endtask

   // Write one register word and mirror it into the shadow registers.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_ROW_WIDTH:   cfg_row_width   = data[RW_W-1:0];
         CSR_WEIGHTS_A:   cfg_weights_a   = data;
         CSR_WEIGHTS_B:   cfg_weights_b   = data;
         CSR_WEIGHTS_C:   cfg_weights_c   = data;
         CSR_WEIGHT_LAST: cfg_weight_last = data[WT_W-1:0];
         CSR_BIAS_CODE:   cfg_bias        = data[WT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Drop valid, wait for every owed result word, then let pixels that owe
   // no result clear the pipeline.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (window_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Change gap rates away from the clock edge so no process races on them.
   task automatic set_idling(input int send_pct, input int recv_pct);
      @(negedge clock);
      req_idle_pct = send_pct;
      rsp_idle_pct = recv_pct;
      @(posedge clock);
   endtask

   // One frame at the current width, each row complete; a broken frame stops
   // early at a random spot and the next frame start cuts in.
   task automatic send_frame(input int rows, input bit full_range, input bit may_break);
      int w;
      int stop_at;
      w       = active_width();
      stop_at = rows * w;
      if (may_break && $urandom_range(7, 0) == 0) stop_at = $urandom_range(rows * w - 1, 1);
      for (int n = 0; n < stop_at; n++)
         send_pixel(random_pixel(full_range), n == 0, random_partial(),
                    1'($urandom_range(1, 0)));
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Registers at reset: width 32, zero weights and bias, so every sum is the
   // saturated partial input.
   task automatic test_reset_defaults();
      send_frame(5, 1'b1, 1'b0);
   endtask

   // Narrowest rows, most negative weights and extreme pixels: one window's
   // sum saturates low and clips to zero, the next clips the activation at the top.
   task automatic test_extremes();
      logic signed [PIX_W-1:0] pix;
      logic signed [ACC_W-1:0] partial;
      drain_results();
      write_reg(CSR_ROW_WIDTH, CSR_DATA_W'(ROW_WIDTH_MIN));
      write_reg(CSR_WEIGHTS_A, {8{8'h80}});
      write_reg(CSR_WEIGHTS_B, {8{8'h80}});
      write_reg(CSR_WEIGHTS_C, {8{8'h80}});
      write_reg(CSR_WEIGHT_LAST, CSR_DATA_W'(8'h80));
      write_reg(CSR_BIAS_CODE, CSR_DATA_W'(8'h7F));
      for (int r = 0; r < KERNEL_SIZE + 1; r++) begin
         for (int c = 0; c < KERNEL_SIZE; c++) begin
            pix     = (r == KERNEL_SIZE) ? 16'sh8000 : 16'sh7FFF;
            partial = (r == KERNEL_SIZE) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            send_pixel(pix, r == 0 && c == 0, partial, 1'b1);
         end
      end
   endtask

   // Shrink the width while the raster sits past the new last column: the
   // next pixel ends the row, and later rows use the new width.
   task automatic test_shrink_mid_row();
      drain_results();
      write_reg(CSR_ROW_WIDTH, CSR_DATA_W'(12));
      write_reg(CSR_WEIGHTS_A, {$urandom, $urandom});
      write_reg(CSR_WEIGHTS_B, {$urandom, $urandom});
      for (int n = 0; n < 5 * 12 + 7; n++)
         send_pixel(random_pixel(1'b1), n == 0, random_partial(), 1'($urandom_range(1, 0)));
      drain_results();
      write_reg(CSR_ROW_WIDTH, CSR_DATA_W'(6));
      for (int n = 0; n < 1 + 2 * 6; n++)
         send_pixel(random_pixel(1'b0), 1'b0, random_partial(), 1'($urandom_range(1, 0)));
   endtask

   // Hold the result side for a long stretch while full-width rows keep
   // coming, so the pipeline fills and pushes back on the pixel side.
   task automatic test_output_backpressure();
      drain_results();
      write_reg(CSR_ROW_WIDTH, CSR_DATA_W'(ROW_WIDTH_MAX));
      write_reg(CSR_WEIGHTS_A, {8{8'h7F}});
      write_reg(CSR_WEIGHTS_B, {8{8'h7F}});
      write_reg(CSR_WEIGHTS_C, {8{8'h7F}});
      write_reg(CSR_WEIGHT_LAST, CSR_DATA_W'(8'h7F));
      write_reg(CSR_BIAS_CODE, CSR_DATA_W'(8'h80));
      @(negedge clock);
      rsp_hold_request = RSP_HOLD_CYCLES;
      @(posedge clock);
      send_frame(6, 1'b1, 1'b0);
   endtask

   // Random frames with random registers in between, until the pixel count
   // reaches the goal. Narrow rows dominate; full-width frames stay short.
   task automatic test_random_frames(input int pixel_goal);
      logic [RW_W-1:0] width_code;
      int              rows;
      while (pixels_sent < pixel_goal) begin
         if ($urandom_range(2, 0) == 0) begin
            drain_results();
            case ($urandom_range(19, 0))
               0, 1:    width_code = RW_W'($urandom_range(4, 0));
               2, 3:    width_code = RW_W'($urandom_range(2047, 33));
               4:       width_code = $urandom_range(1, 0) ? 11'd2047 : 11'd1024;
               5, 6, 7: width_code = RW_W'($urandom_range(32, 11));
               default: width_code = RW_W'($urandom_range(10, 5));
            endcase
            write_reg(CSR_ROW_WIDTH, CSR_DATA_W'(width_code));
            if ($urandom_range(1, 0)) write_reg(CSR_WEIGHTS_A, {$urandom, $urandom});
            if ($urandom_range(1, 0)) write_reg(CSR_WEIGHTS_B, {$urandom, $urandom});
            if ($urandom_range(1, 0)) write_reg(CSR_WEIGHTS_C, {$urandom, $urandom});
            if ($urandom_range(1, 0))
               write_reg(CSR_WEIGHT_LAST, CSR_DATA_W'($urandom_range(255, 0)));
            write_reg(CSR_BIAS_CODE, CSR_DATA_W'($urandom_range(255, 0)));
            // Unmapped index: the block must drop it.
            if ($urandom_range(3, 0) == 0)
               write_reg(CSR_IDX_W'($urandom_range(2 ** CSR_IDX_W - 1, CSR_UNMAPPED_FIRST)),
                         {$urandom, $urandom});
         end
         rows = (active_width() > 16) ? $urandom_range(6, 5) : $urandom_range(9, 5);
         send_frame(rows, $urandom_range(3, 0) != 0, 1'b1);
      end
   endtask

   // ---------------------------------------------------------------------
   // Result side: ready with random gaps, plus the long hold on request
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (rsp_hold_request != 0) begin
         rsp_hold_left    = rsp_hold_request;
         rsp_hold_request = 0;
      end
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99, 0) >= rsp_idle_pct);
      end
   end

   // Compare every accepted result word with the oldest owed one.
   always @(posedge clock) begin : check_results
      window_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (window_results.size() == 0) begin
            if (fail_count < MAX_REPORTS)
               $display("unexpected result word: sum %0d activation %0d row_end %0b",
                        rsp_sum_out, rsp_activation, rsp_row_end);
            fail_count++;
         end else begin
            want = window_results.pop_front();
            if (rsp_sum_out !== want.sum || rsp_activation !== want.act ||
                rsp_row_end !== want.row_end) begin
               if (fail_count < MAX_REPORTS)
                  $display("mismatch: expected sum %0d act %0d end %0b, got sum %0d act %0d end %0b",
                           want.sum, want.act, want.row_end,
                           rsp_sum_out, rsp_activation, rsp_row_end);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: end the run once no channel has moved a word for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Sender mostly busy, receiver often stalled.
      set_idling(7, 61);
      test_reset_defaults();
      test_extremes();
      test_random_frames(600);

      // Sender often idle, receiver mostly ready.
      set_idling(61, 7);
      test_shrink_mid_row();
      test_random_frames(1000);

      // No idling on either side, apart from the long hold.
      set_idling(0, 0);
      test_output_backpressure();
      test_random_frames(1350);

      drain_results();
      if (fail_count == 0 && window_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
